>>> hdl/prt_pkg.sv
// Shared types, constants and helpers for the pending request tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package prt_pkg;

  localparam int SLOTS   = 8;
  localparam int MAX_OUT = 8;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;

  localparam logic [15:0] DEF_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  SCAN_RELOAD_RST = 8'd20;

  localparam logic [7:0] REG_DEFAULT_TIMEOUT = 8'd0;
  localparam logic [7:0] REG_SCAN_RELOAD     = 8'd1;

  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,
    OP_RESP = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_REJECT  = 3'd1,
    KIND_DONE_OK = 3'd2,
    KIND_DONE_PE = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot;
    logic [6:0]  node_id;
    logic [15:0] obj_index;
    logic [7:0]  sub_index;
    logic [2:0]  data_len;
    logic [31:0] data;
  } result_t;

  typedef struct packed {
    logic             accept;
    logic [IDX_W-1:0] idx;
    logic             set_pick;
    logic             clear_slot;
    logic             dec_slot;
    logic             hold_load;
    kind_e            hold_kind;
    logic             commit;
    logic             flush;
  } cmd_t;

  typedef struct packed {
    op_e  in_op;
    op_e  op;
    logic pre_zero;
    logic match;
    logic busy;
    logic expire;
    logic cnt_ok;
    logic hold_vld;
    logic out_free;
    logic pick_vld;
  } stat_t;

  function automatic logic [2:0] slot_field(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[2:0];
  endfunction

endpackage

>>> hdl/pending_request_tracker_unit.sv
// Pending request tracker: table of outstanding request slots with timeouts.
// Open walks to a match or the last slot; response and scan walk all slots; a plain tick
// only steps the prescaler. One slot a cycle is visited, and one word is handled at a time.
// Result words are staged through a hold and output register; a stalled master side
// holds the walk. Reset (async, active low) frees all slots and loads register defaults.
`timescale 1ns / 1ps

module pending_request_tracker_unit
  import prt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  // request / response / tick words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // frame_id[10:0], object_index[26:11], sub_index[34:27], wait_scans[50:35],
  // peer_error[51], payload_len[55:52], payload[87:56]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser,
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slot[2:0], node_id[9:3], obj_index_out[25:10], sub_index_out[33:26],
  // data_len[36:34], data_out[68:37], zero fill[71:69]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;

  prt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> hdl/prt_ctrl.sv
// Sequencer for the pending request tracker: walks the slot table per word.
// Depends on prt_pkg; drives prt_datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module prt_ctrl
  import prt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_idx;
  logic             step_en;

  assign last_idx   = (idx_q == IDX_W'(SLOTS - 1));
  assign step_en    = stat_i.out_free || !stat_i.hold_vld;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx       = idx_q;
    cmd_o.hold_kind = KIND_REJECT;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          idx_d = '0;
          if (stat_i.in_op == OP_OPEN || stat_i.in_op == OP_RESP ||
              (stat_i.in_op == OP_TICK && stat_i.pre_zero)) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (step_en) begin
          case (stat_i.op)
            OP_OPEN: begin
              if (stat_i.match && stat_i.busy) begin
                cmd_o.hold_load = 1'b1;
                cmd_o.hold_kind = KIND_REJECT;
                state_d = ST_FLUSH;
              end else if (stat_i.match) begin
                cmd_o.set_pick = 1'b1;
                state_d = ST_COMMIT;
              end else begin
                cmd_o.set_pick = !stat_i.busy && !stat_i.pick_vld;
                if (last_idx) state_d = ST_COMMIT;
                else idx_d = idx_q + 1'b1;
              end
            end
            OP_RESP: begin
              if (stat_i.match && stat_i.busy) begin
                cmd_o.clear_slot = 1'b1;
                cmd_o.hold_load  = stat_i.cnt_ok;
                cmd_o.hold_kind  = KIND_DONE_OK;
              end
              if (last_idx) state_d = ST_FLUSH;
              else idx_d = idx_q + 1'b1;
            end
            OP_TICK: begin
              if (stat_i.busy) begin
                cmd_o.dec_slot  = 1'b1;
                cmd_o.hold_load = stat_i.expire && stat_i.cnt_ok;
                cmd_o.hold_kind = KIND_TIMEOUT;
              end
              if (last_idx) state_d = ST_FLUSH;
              else idx_d = idx_q + 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat_i.hold_vld) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> hdl/prt_datapath.sv
// Slot table, request latch, prescaler, config registers and result staging.
// Depends on prt_pkg; commanded by prt_ctrl.
`timescale 1ns / 1ps

module prt_datapath
  import prt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [1:0]            in_op_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [2:0]            out_kind_o,
  output logic                  out_last_o,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o
);

  logic [15:0] def_timeout_q;
  logic [7:0]  scan_reload_q;
  logic [7:0]  pre_q;

  logic [10:0] slot_fid_q  [SLOTS];
  logic [15:0] slot_oidx_q [SLOTS];
  logic [7:0]  slot_sidx_q [SLOTS];
  logic [15:0] slot_scans_q[SLOTS];

  op_e         op_q;
  logic [10:0] fid_q;
  logic [15:0] oidx_q;
  logic [7:0]  sidx_q;
  logic [15:0] wait_q;
  logic        perr_q;
  logic [2:0]  dlen_q;
  logic [31:0] data_q;

  logic [3:0]  in_plen;
  logic [31:0] in_payload;
  logic [2:0]  in_dlen;
  logic [31:0] in_data_m;

  logic [IDX_W-1:0] pick_q;
  logic             pick_vld_q;
  logic [CNT_W-1:0] cnt_q;
  result_t          hold_q, hold_d;
  logic             hold_vld_q;
  result_t          out_q;
  logic             out_vld_q, out_last_q;

  logic        hold_ld, push;
  logic [15:0] load_scans;
  logic [10:0] cur_fid;
  logic [15:0] cur_oidx;
  logic [7:0]  cur_sidx;
  logic [15:0] cur_scans;

  assign cfg_ready_o = 1'b1;

  assign in_plen    = in_data_i[55:52];
  assign in_payload = in_data_i[87:56];
  assign in_dlen    = (in_plen > 4'd4) ? 3'd4 : in_plen[2:0];

  always_comb begin
    case (in_dlen)
      3'd0:    in_data_m = 32'h0;
      3'd1:    in_data_m = in_payload & 32'h0000_00ff;
      3'd2:    in_data_m = in_payload & 32'h0000_ffff;
      3'd3:    in_data_m = in_payload & 32'h00ff_ffff;
      default: in_data_m = in_payload;
    endcase
  end

  assign cur_fid   = slot_fid_q[cmd_i.idx];
  assign cur_oidx  = slot_oidx_q[cmd_i.idx];
  assign cur_sidx  = slot_sidx_q[cmd_i.idx];
  assign cur_scans = slot_scans_q[cmd_i.idx];

  assign load_scans = (wait_q != 16'd0) ? wait_q :
                      (def_timeout_q != 16'd0) ? def_timeout_q : 16'd1;

  assign hold_ld = cmd_i.hold_load || cmd_i.commit;
  assign push    = (hold_ld && hold_vld_q) || cmd_i.flush;

  always_comb begin
    hold_d           = '0;
    hold_d.node_id   = fid_q[6:0];
    hold_d.obj_index = oidx_q;
    hold_d.sub_index = sidx_q;
    hold_d.slot      = slot_field(cmd_i.idx);
    if (cmd_i.commit) begin
      hold_d.kind = pick_vld_q ? KIND_ACCEPT : KIND_REJECT;
      hold_d.slot = pick_vld_q ? slot_field(pick_q) : 3'd0;
    end else begin
      case (cmd_i.hold_kind)
        KIND_DONE_OK: begin
          hold_d.kind     = perr_q ? KIND_DONE_PE : KIND_DONE_OK;
          hold_d.data_len = dlen_q;
          hold_d.data     = data_q;
        end
        KIND_TIMEOUT: begin
          hold_d.kind      = KIND_TIMEOUT;
          hold_d.node_id   = cur_fid[6:0];
          hold_d.obj_index = cur_oidx;
          hold_d.sub_index = cur_sidx;
        end
        default: hold_d.kind = KIND_REJECT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_timeout_q <= DEF_TIMEOUT_RST;
      scan_reload_q <= SCAN_RELOAD_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_DEFAULT_TIMEOUT) def_timeout_q <= cfg_data_i;
      else if (cfg_index_i == REG_SCAN_RELOAD) scan_reload_q <= cfg_data_i[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= SCAN_RELOAD_RST;
    end else if (cmd_i.accept && op_e'(in_op_i) == OP_TICK) begin
      pre_q <= (pre_q == 8'd0) ? scan_reload_q : pre_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_fid_q[i]   <= '0;
        slot_oidx_q[i]  <= '0;
        slot_sidx_q[i]  <= '0;
        slot_scans_q[i] <= '0;
      end
    end else if (cmd_i.commit && pick_vld_q) begin
      slot_fid_q[pick_q]   <= fid_q;
      slot_oidx_q[pick_q]  <= oidx_q;
      slot_sidx_q[pick_q]  <= sidx_q;
      slot_scans_q[pick_q] <= load_scans;
    end else if (cmd_i.clear_slot) begin
      slot_scans_q[cmd_i.idx] <= '0;
    end else if (cmd_i.dec_slot) begin
      slot_scans_q[cmd_i.idx] <= cur_scans - 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(in_op_i);
      fid_q  <= in_data_i[10:0];
      oidx_q <= in_data_i[26:11];
      sidx_q <= in_data_i[34:27];
      wait_q <= in_data_i[50:35];
      perr_q <= in_data_i[51];
      dlen_q <= in_dlen;
      data_q <= in_data_m;
    end
    if (cmd_i.set_pick) pick_q <= cmd_i.idx;
    if (hold_ld) hold_q <= hold_d;
    if (push) begin
      out_q      <= hold_q;
      out_last_q <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_vld_q <= 1'b0;
      cnt_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        pick_vld_q <= 1'b0;
        cnt_q      <= '0;
      end else begin
        if (cmd_i.set_pick) pick_vld_q <= 1'b1;
        if (hold_ld) cnt_q <= cnt_q + 1'b1;
      end
      if (hold_ld) hold_vld_q <= 1'b1;
      else if (cmd_i.flush) hold_vld_q <= 1'b0;
      if (push) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign stat_o.in_op    = op_e'(in_op_i);
  assign stat_o.op       = op_q;
  assign stat_o.pre_zero = (pre_q == 8'd0);
  assign stat_o.match    = (cur_fid == fid_q) && (cur_oidx == oidx_q) &&
                           (cur_sidx == sidx_q);
  assign stat_o.busy     = (cur_scans != 16'd0);
  assign stat_o.expire   = (cur_scans == 16'd1);
  assign stat_o.cnt_ok   = (cnt_q < CNT_W'(MAX_OUT));
  assign stat_o.hold_vld = hold_vld_q;
  assign stat_o.out_free = !out_vld_q || out_ready_i;
  assign stat_o.pick_vld = pick_vld_q;

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = out_q.kind;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {3'd0, out_q.data, out_q.data_len, out_q.sub_index,
                        out_q.obj_index, out_q.node_id, out_q.slot};

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_vld_q || out_ready_i))
    else $error("result pushed over an untaken word");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hold_load |-> (cnt_q < CNT_W'(MAX_OUT)))
    else $error("result count above limit");

  a_commit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && pick_vld_q) |=> (slot_scans_q[$past(pick_q)] != 16'd0))
    else $error("accepted slot left free");

  a_flush_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |-> hold_vld_q)
    else $error("flush without staged result");

endmodule

>>> dv/pending_request_tracker_unit_tb.sv
// Self-checking testbench for pending_request_tracker_unit: directed and random request,
// response and tick words, checked against an in-bench slot table predictor.
// Depends on prt_pkg and the pending_request_tracker_unit RTL.
`timescale 1ns / 1ps

module pending_request_tracker_unit_tb;
  import prt_pkg::*;

  localparam logic [7:0] REG_SPARE = 8'd5;
  localparam int         POOL      = 10;
  localparam int         SETTLE    = 2 * SLOTS + 4;

  typedef struct packed {
    logic [10:0] fid;
    logic [15:0] oidx;
    logic [7:0]  sidx;
  } key_t;

  typedef struct packed {
    op_e         op;
    key_t        key;
    logic [15:0] wait_scans;
    logic        peer_err;
    logic [3:0]  plen;
    logic [31:0] payload;
  } req_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot;
    logic [6:0]  node;
    logic [15:0] oidx;
    logic [7:0]  sidx;
    logic [2:0]  dlen;
    logic [31:0] data;
    logic        last;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [7:0]            cfg_index_i = '0;
  logic [15:0]           cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  pending_request_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // slot table mirror
  key_t        tab_key [SLOTS];
  logic [15:0] tab_left [SLOTS];
  logic [15:0] reg_timeout;
  logic [7:0]  reg_reload;
  logic [7:0]  tick_div;

  req_word_t word_q[$];
  outcome_t  outcome_q[$];
  req_word_t cur_word;
  logic      word_live = 1'b0;
  key_t      key_pool [POOL];
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        errors = 0;
  outcome_t  seen;
  outcome_t  want;

  int ph_timeout [4] = '{3, 1, 40, 65535};
  int ph_reload  [4] = '{0, 2, 1, 255};
  int ph_idle    [4] = '{0, 77, 0, 10};
  int ph_stall   [4] = '{0, 0, 77, 10};

  function automatic outcome_t make_outcome(kind_e k, int s, key_t key, logic [2:0] dl,
                                            logic [31:0] dt, logic lst);
    outcome_t o;
    o.kind = k;
    o.slot = 3'(s);
    o.node = key.fid[6:0];
    o.oidx = key.oidx;
    o.sidx = key.sidx;
    o.dlen = dl;
    o.data = dt;
    o.last = lst;
    return o;
  endfunction

  task automatic predict_outcome(input req_word_t w);
    int       pick;
    int       n;
    logic     decided;
    logic     busy_hit;
    logic     have;
    outcome_t held;
    logic [2:0]  dl;
    logic [31:0] dt;
    pick = -1;
    n = 0;
    decided = 1'b0;
    busy_hit = 1'b0;
    have = 1'b0;
    held = '0;
    case (w.op)
      OP_OPEN: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!decided) begin
            if (tab_key[i] == w.key) begin
              decided = 1'b1;
              busy_hit = (tab_left[i] != 0);
              pick = i;
            end else if (pick < 0 && tab_left[i] == 0) begin
              pick = i;
            end
          end
        end
        if (busy_hit || pick < 0) begin
          outcome_q.push_back(make_outcome(KIND_REJECT, busy_hit ? pick : 0, w.key, 3'd0,
                                           32'd0, 1'b1));
        end else begin
          tab_key[pick] = w.key;
          tab_left[pick] = (w.wait_scans != 0) ? w.wait_scans :
                           (reg_timeout != 0) ? reg_timeout : 16'd1;
          outcome_q.push_back(make_outcome(KIND_ACCEPT, pick, w.key, 3'd0, 32'd0, 1'b1));
        end
      end
      OP_RESP: begin
        dl = (w.plen > 4'd4) ? 3'd4 : w.plen[2:0];
        dt = (dl == 3'd4) ? w.payload : (w.payload & ((32'd1 << (8 * dl)) - 32'd1));
        for (int i = 0; i < SLOTS; i++) begin
          if (tab_left[i] != 0 && tab_key[i] == w.key) begin
            tab_left[i] = 16'd0;
            if (n < MAX_OUT) begin
              if (have) outcome_q.push_back(held);
              held = make_outcome(w.peer_err ? KIND_DONE_PE : KIND_DONE_OK, i, w.key, dl, dt,
                                  1'b0);
              have = 1'b1;
              n++;
            end
          end
        end
      end
      OP_TICK: begin
        if (tick_div != 0) begin
          tick_div = tick_div - 8'd1;
        end else begin
          tick_div = reg_reload;
          for (int i = 0; i < SLOTS; i++) begin
            if (tab_left[i] != 0) begin
              tab_left[i] = tab_left[i] - 16'd1;
              if (tab_left[i] == 0 && n < MAX_OUT) begin
                if (have) outcome_q.push_back(held);
                held = make_outcome(KIND_TIMEOUT, i, tab_key[i], 3'd0, 32'd0, 1'b0);
                have = 1'b1;
                n++;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (have) begin
      held.last = 1'b1;
      outcome_q.push_back(held);
    end
  endtask

  function automatic req_word_t mk_word(op_e op, key_t k, logic [15:0] ws, logic pe,
                                        logic [3:0] pl, logic [31:0] pd);
    req_word_t w;
    w.op = op;
    w.key = k;
    w.wait_scans = ws;
    w.peer_err = pe;
    w.plen = pl;
    w.payload = pd;
    return w;
  endfunction

  function automatic key_t fill_key(int i);
    key_t k;
    k.fid = 11'(100 + i);
    k.oidx = 16'(16'h1000 + i);
    k.sidx = 8'(i);
    return k;
  endfunction

  function automatic req_word_t random_word();
    req_word_t w;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 40) w.op = OP_OPEN;
    else if (roll < 68) w.op = OP_RESP;
    else if (roll < 96) w.op = OP_TICK;
    else w.op = OP_NONE;
    w.key = key_pool[$urandom_range(POOL - 1)];
    if ($urandom_range(9) == 0) begin
      w.key.fid = 11'($urandom());
      w.key.oidx = 16'($urandom());
      w.key.sidx = 8'($urandom());
    end
    roll = $urandom_range(99);
    if (roll < 30) w.wait_scans = 16'd0;
    else if (roll < 85) w.wait_scans = 16'($urandom_range(8, 1));
    else w.wait_scans = 16'($urandom());
    w.peer_err = 1'($urandom_range(1));
    w.plen = 4'($urandom_range(8));
    w.payload = $urandom();
    return w;
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_DEFAULT_TIMEOUT) reg_timeout = val;
    else if (idx == REG_SCAN_RELOAD) reg_reload = val[7:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (word_q.size() != 0 || word_live || outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic show_outcome(input string tag, input outcome_t o);
    $display("  %s kind %0d slot %0d node %h index %h sub %h len %0d data %h last %b",
             tag, o.kind, o.slot, o.node, o.oidx, o.sidx, o.dlen, o.data, o.last);
  endtask

  // driver: hold a word until taken, then advance or idle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!word_live) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_word = word_q.pop_front();
          word_live = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_word.payload, cur_word.plen, cur_word.peer_err,
                           cur_word.wait_scans, cur_word.key.sidx, cur_word.key.oidx,
                           cur_word.key.fid};
          s_axis_tuser <= cur_word.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outcome(cur_word);
        word_live = 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind = kind_e'(m_axis_tuser);
        seen.slot = m_axis_tdata[2:0];
        seen.node = m_axis_tdata[9:3];
        seen.oidx = m_axis_tdata[25:10];
        seen.sidx = m_axis_tdata[33:26];
        seen.dlen = m_axis_tdata[36:34];
        seen.data = m_axis_tdata[68:37];
        seen.last = m_axis_tlast;
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result word with none expected", $realtime);
            show_outcome("got ", seen);
          end
        end else begin
          want = outcome_q.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result word mismatch", $realtime);
              show_outcome("want", want);
              show_outcome("got ", seen);
            end
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("pending_request_tracker_unit regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tab_key[i] = '0;
      tab_left[i] = '0;
    end
    reg_timeout = DEF_TIMEOUT_RST;
    reg_reload = SCAN_RELOAD_RST;
    tick_div = SCAN_RELOAD_RST;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    word_q.push_back(mk_word(OP_OPEN, '0, 16'd0, 1'b0, 4'd0, 32'd0));
    word_q.push_back(mk_word(OP_OPEN, '0, 16'd5, 1'b0, 4'd0, 32'd0));
    word_q.push_back(mk_word(OP_OPEN, '1, 16'hffff, 1'b1, 4'd8, 32'hffff_ffff));
    word_q.push_back(mk_word(OP_RESP, '1, 16'hffff, 1'b0, 4'd8, 32'hffff_ffff));
    word_q.push_back(mk_word(OP_RESP, '1, 16'd0, 1'b0, 4'd1, 32'h1234_5678));
    word_q.push_back(mk_word(OP_RESP, '0, 16'd0, 1'b1, 4'd0, $urandom()));
    word_q.push_back(mk_word(OP_NONE, '1, 16'hffff, 1'b1, 4'hf, 32'hffff_ffff));
    for (int i = 0; i < SLOTS; i++) begin
      word_q.push_back(mk_word(OP_OPEN, fill_key(i), 16'd1, 1'b0, 4'd0, 32'd0));
    end
    word_q.push_back(mk_word(OP_OPEN, fill_key(8), 16'd1, 1'b0, 4'd0, 32'd0));
    word_q.push_back(mk_word(OP_OPEN, fill_key(3), 16'd9, 1'b0, 4'd0, 32'd0));
    drain_results();

    write_reg(REG_DEFAULT_TIMEOUT, 16'd0);
    write_reg(REG_SCAN_RELOAD, 16'd0);
    word_q.push_back(mk_word(OP_RESP, fill_key(5), 16'd0, 1'b0, 4'd3, $urandom()));
    word_q.push_back(mk_word(OP_OPEN, fill_key(9), 16'd0, 1'b0, 4'd0, 32'd0));
    word_q.push_back(mk_word(OP_RESP, fill_key(2), 16'd0, 1'b1, 4'd2, $urandom()));
    word_q.push_back(mk_word(OP_OPEN, fill_key(2), 16'd0, 1'b0, 4'd0, 32'd0));
    // run the prescaler down to its first scan: every slot expires at once
    repeat (SCAN_RELOAD_RST + 1) begin
      word_q.push_back(mk_word(OP_TICK, '0, 16'd0, 1'b0, 4'd0, 32'd0));
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_DEFAULT_TIMEOUT, 16'(ph_timeout[p]));
      write_reg(REG_SCAN_RELOAD, {8'($urandom()), 8'(ph_reload[p])});
      if (p == 3) write_reg(REG_SPARE, 16'($urandom()));
      idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      for (int k = 0; k < POOL; k++) begin
        key_pool[k].fid = 11'($urandom());
        key_pool[k].oidx = 16'($urandom());
        key_pool[k].sidx = 8'($urandom());
      end
      repeat (21) word_q.push_back(random_word());
      // hold the sender until every result is in
      drain_results();
      repeat (21) word_q.push_back(random_word());
      drain_results();
    end

    if (outcome_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("pending_request_tracker_unit regression: pass");
    end else begin
      $display("pending_request_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/prt_pkg.sv
hdl/prt_ctrl.sv
hdl/prt_datapath.sv
hdl/pending_request_tracker_unit.sv
dv/pending_request_tracker_unit_tb.sv
